### rtl/assert_macros.svh
// assertion macros for the rtl files that check themselves
// depends on: a clock named clock and a synchronous reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define DDT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define DDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ddt_pkg.sv
// shared constants and types of the dataflow dependency tracker
// depends on: nothing
package ddt_pkg;

   // request kinds
   localparam logic [1:0] REQ_TRACE = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // fixed field widths
   localparam int FIELD_W = 5;
   localparam int OPLAT_W = 10;
   localparam int IDX_W   = 12;
   localparam int PROD_W  = 13;
   localparam int TIME_W  = 22;
   localparam int FCNT_W  = 13;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};
   localparam logic [PROD_W-1:0] NO_PROD  = {PROD_W{1'b1}};

   // parameter defaults
   localparam int DEF_NUM_REGS     = 32;
   localparam int DEF_NUM_OPCODES  = 32;
   localparam int DEF_MAX_INSTS    = 4096;
   localparam int DEF_LATENCY_BITS = 10;

   // table control from the pipeline
   typedef struct packed {
      logic rd;   // request accepted, launch reads
      logic wr;   // stage one commits a write
      logic clr;  // stage one commits a clear
   } tab_ctl_type;

endpackage

### rtl/dataflow_dependency_tracker.sv
// path: a trace request passes the stage one register and then the response register
// throughput: one request per cycle while the response is not stalled, set by the registered read of the table rams
// with forwarding of the write made by the request just ahead
// reset: clears tracking, the latency table (through entry valid bits), counters
// and both pipeline stages at once; there is no clearing pass
module dataflow_dependency_tracker import ddt_pkg::*; #(
   parameter int NUM_REGS     = DEF_NUM_REGS,
   parameter int NUM_OPCODES  = DEF_NUM_OPCODES,
   parameter int MAX_INSTS    = DEF_MAX_INSTS,
   parameter int LATENCY_BITS = DEF_LATENCY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic [FIELD_W-1:0]       req_opcode,
   input  logic [FIELD_W-1:0]       req_src_a,
   input  logic [FIELD_W-1:0]       req_src_b,
   input  logic [FIELD_W-1:0]       req_dest_reg,
   input  logic [OPLAT_W-1:0]       req_op_latency,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_status,
   output logic [IDX_W-1:0]         rsp_inst_index,
   output logic signed [PROD_W-1:0] rsp_producer_a,
   output logic signed [PROD_W-1:0] rsp_producer_b,
   output logic [TIME_W-1:0]        rsp_start_depth,
   output logic [TIME_W-1:0]        rsp_finish_time,
   output logic [TIME_W-1:0]        rsp_program_depth,
   output logic [FCNT_W-1:0]        rsp_dest_false_deps
);

`include "assert_macros.svh"

   localparam int REG_AW = $clog2(NUM_REGS);
   localparam int OP_AW  = $clog2(NUM_OPCODES);
   localparam int WR_W   = $clog2(MAX_INSTS);
   localparam int CNT_W  = $clog2(MAX_INSTS + 1);
   localparam int SUM_W  = ((TIME_W > LATENCY_BITS) ? TIME_W : LATENCY_BITS) + 1;

   // handshake
   logic advance;
   logic accept;
   logic fire;

   // stage one request
   logic                    s1_valid_ff;
   logic [1:0]              s1_kind_ff;
   logic [FIELD_W-1:0]      s1_sa_ff;
   logic [FIELD_W-1:0]      s1_sb_ff;
   logic [FIELD_W-1:0]      s1_dst_ff;
   logic [LATENCY_BITS-1:0] s1_lat_ff;
   logic [OP_AW-1:0]        s1_op_addr_ff;
   logic [REG_AW-1:0]       s1_sa_addr_ff;
   logic [REG_AW-1:0]       s1_sb_addr_ff;
   logic [REG_AW-1:0]       s1_dst_addr_ff;
   logic                    s1_op_ok_ff;
   logic                    s1_sa_ok_ff;
   logic                    s1_sb_ok_ff;
   logic                    s1_dst_ok_ff;

   // trace state
   logic [CNT_W-1:0]   inst_count_ff;
   logic [CNT_W-1:0]   inst_count_in;
   logic [TIME_W-1:0]  depth_max_ff;
   logic [FIELD_W-1:0] prev_src_a_ff;
   logic [FIELD_W-1:0] prev_src_b_ff;
   logic [FIELD_W-1:0] prev_dest_ff;
   logic               prev_valid_ff;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [PROD_W-1:0] rsp_prod_a_ff;
   logic [PROD_W-1:0] rsp_prod_b_ff;
   logic [TIME_W-1:0] rsp_start_ff;
   logic [TIME_W-1:0] rsp_fin_ff;
   logic [TIME_W-1:0] rsp_depth_ff;
   logic [FCNT_W-1:0] rsp_fcnt_ff;

   // table interface
   tab_ctl_type             reg_ctl;
   tab_ctl_type             lat_ctl;
   logic                    a_hit;
   logic [WR_W-1:0]         a_writer;
   logic [TIME_W-1:0]       a_fin;
   logic                    b_hit;
   logic [WR_W-1:0]         b_writer;
   logic [TIME_W-1:0]       b_fin;
   logic                    d_hit;
   logic [FCNT_W-1:0]       d_cnt;
   logic [LATENCY_BITS-1:0] lat;

   // stage one computation
   logic               is_trace;
   logic               full;
   logic               go;
   logic               clr_fire;
   logic [TIME_W-1:0]  fin_a;
   logic [TIME_W-1:0]  fin_b;
   logic [TIME_W-1:0]  start;
   logic [SUM_W-1:0]   fin_sum;
   logic [TIME_W-1:0]  fin;
   logic [TIME_W-1:0]  depth_new;
   logic [PROD_W-1:0]  prod_a;
   logic [PROD_W-1:0]  prod_b;
   logic               war_waw;
   logic [FCNT_W-1:0]  cnt_old;
   logic [FCNT_W-1:0]  cnt_new;

   // handshake: the response register parts the two sides
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign fire      = s1_valid_ff && advance;

   // stage one capture, table reads launch on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= req_type;
         s1_sa_ff       <= req_src_a;
         s1_sb_ff       <= req_src_b;
         s1_dst_ff      <= req_dest_reg;
         s1_lat_ff      <= LATENCY_BITS'(req_op_latency);
         s1_op_addr_ff  <= OP_AW'(req_opcode);
         s1_sa_addr_ff  <= REG_AW'(req_src_a);
         s1_sb_addr_ff  <= REG_AW'(req_src_b);
         s1_dst_addr_ff <= REG_AW'(req_dest_reg);
         s1_op_ok_ff    <= 32'(req_opcode) < 32'(NUM_OPCODES);
         s1_sa_ok_ff    <= 32'(req_src_a) < 32'(NUM_REGS);
         s1_sb_ok_ff    <= 32'(req_src_b) < 32'(NUM_REGS);
         s1_dst_ok_ff   <= 32'(req_dest_reg) < 32'(NUM_REGS);
      end
   end

   // request decode in stage one
   assign is_trace = s1_kind_ff == REQ_TRACE;
   assign full     = inst_count_ff >= CNT_W'(MAX_INSTS);
   assign go       = fire && is_trace && !full;
   assign clr_fire = fire && s1_kind_ff == REQ_CLEAR;

   // table control
   assign reg_ctl.rd  = accept;
   assign reg_ctl.wr  = go && s1_dst_ok_ff;
   assign reg_ctl.clr = clr_fire;
   assign lat_ctl.rd  = accept;
   assign lat_ctl.wr  = fire && s1_kind_ff == REQ_LOAD && s1_op_ok_ff;
   assign lat_ctl.clr = 1'b0;

   ddt_regtab #(
      .NUM_REGS  (NUM_REGS),
      .MAX_INSTS (MAX_INSTS)
   ) u_regtab (
      .clock     (clock),
      .reset     (reset),
      .ctl       (reg_ctl),
      .rd_addr_a (REG_AW'(req_src_a)),
      .rd_addr_b (REG_AW'(req_src_b)),
      .rd_addr_d (REG_AW'(req_dest_reg)),
      .lk_addr_a (s1_sa_addr_ff),
      .lk_addr_b (s1_sb_addr_ff),
      .lk_addr_d (s1_dst_addr_ff),
      .lk_ok_a   (s1_sa_ok_ff),
      .lk_ok_b   (s1_sb_ok_ff),
      .lk_ok_d   (s1_dst_ok_ff),
      .wr_addr   (s1_dst_addr_ff),
      .wr_writer (WR_W'(inst_count_ff)),
      .wr_fin    (fin),
      .wr_cnt    (cnt_new),
      .a_hit     (a_hit),
      .a_writer  (a_writer),
      .a_fin     (a_fin),
      .b_hit     (b_hit),
      .b_writer  (b_writer),
      .b_fin     (b_fin),
      .d_hit     (d_hit),
      .d_cnt     (d_cnt)
   );

   ddt_lattab #(
      .NUM_OPCODES  (NUM_OPCODES),
      .LATENCY_BITS (LATENCY_BITS)
   ) u_lattab (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lat_ctl),
      .rd_addr (OP_AW'(req_opcode)),
      .lk_addr (s1_op_addr_ff),
      .lk_ok   (s1_op_ok_ff),
      .wr_addr (s1_op_addr_ff),
      .wr_data (s1_lat_ff),
      .lat     (lat)
   );

   // producers and start depth
   assign prod_a = a_hit ? PROD_W'(a_writer) : NO_PROD;
   assign prod_b = b_hit ? PROD_W'(b_writer) : NO_PROD;
   assign fin_a  = a_hit ? a_fin : '0;
   assign fin_b  = b_hit ? b_fin : '0;
   assign start  = (fin_a > fin_b) ? fin_a : fin_b;

   // finish time, saturating
   assign fin_sum   = SUM_W'(start) + SUM_W'(lat);
   assign fin       = (fin_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_W'(fin_sum);
   assign depth_new = (fin > depth_max_ff) ? fin : depth_max_ff;

   // false dependency count of the destination, saturating
   assign war_waw = prev_valid_ff && (s1_dst_ff == prev_dest_ff ||
                    s1_dst_ff == prev_src_a_ff || s1_dst_ff == prev_src_b_ff);
   assign cnt_old = d_hit ? d_cnt : '0;
   assign cnt_new = (war_waw && cnt_old != FCNT_MAX) ? cnt_old + FCNT_W'(1) : cnt_old;

   assign inst_count_in = inst_count_ff + CNT_W'(1);

   // trace state update
   always_ff @(posedge clock) begin
      if (reset || clr_fire) begin
         inst_count_ff <= '0;
         depth_max_ff  <= '0;
         prev_src_a_ff <= '0;
         prev_src_b_ff <= '0;
         prev_dest_ff  <= '0;
         prev_valid_ff <= 1'b0;
      end else if (go) begin
         inst_count_ff <= inst_count_in;
         depth_max_ff  <= depth_new;
         prev_src_a_ff <= s1_sa_ff;
         prev_src_b_ff <= s1_sb_ff;
         prev_dest_ff  <= s1_dst_ff;
         prev_valid_ff <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire && is_trace;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_trace) begin
         rsp_status_ff <= full;
         if (full) begin
            rsp_index_ff  <= '0;
            rsp_prod_a_ff <= NO_PROD;
            rsp_prod_b_ff <= NO_PROD;
            rsp_start_ff  <= '0;
            rsp_fin_ff    <= '0;
            rsp_depth_ff  <= depth_max_ff;
            rsp_fcnt_ff   <= '0;
         end else begin
            rsp_index_ff  <= IDX_W'(inst_count_ff);
            rsp_prod_a_ff <= prod_a;
            rsp_prod_b_ff <= prod_b;
            rsp_start_ff  <= start;
            rsp_fin_ff    <= fin;
            rsp_depth_ff  <= depth_new;
            rsp_fcnt_ff   <= s1_dst_ok_ff ? cnt_new : '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_inst_index      = rsp_index_ff;
   assign rsp_producer_a      = rsp_prod_a_ff;
   assign rsp_producer_b      = rsp_prod_b_ff;
   assign rsp_start_depth     = rsp_start_ff;
   assign rsp_finish_time     = rsp_fin_ff;
   assign rsp_program_depth   = rsp_depth_ff;
   assign rsp_dest_false_deps = rsp_fcnt_ff;

   // checks
   `DDT_ASSERT_NEXT(a_count_step, go, inst_count_ff == $past(inst_count_ff) + CNT_W'(1), "instruction count did not step on a recorded request")
   `DDT_ASSERT_NEXT(a_depth_mono, !clr_fire, depth_max_ff >= $past(depth_max_ff), "program depth fell without a clear")
   `DDT_ASSERT_IMPL(a_rsp_order, rsp_valid && !rsp_status, rsp_finish_time >= rsp_start_depth && rsp_program_depth >= rsp_finish_time, "response times out of order")

endmodule

### rtl/ddt_ram.sv
// generic single write port, single read port ram with registered read
// depends on: nothing
module ddt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write, read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ddt_lattab.sv
// per-opcode latency table: ram, entry valid bits and write forwarding
// depends on: ddt_pkg, ddt_ram
module ddt_lattab import ddt_pkg::*; #(
   parameter int NUM_OPCODES  = DEF_NUM_OPCODES,
   parameter int LATENCY_BITS = DEF_LATENCY_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tab_ctl_type                    ctl,
   input  logic [$clog2(NUM_OPCODES)-1:0] rd_addr,
   input  logic [$clog2(NUM_OPCODES)-1:0] lk_addr,
   input  logic                           lk_ok,
   input  logic [$clog2(NUM_OPCODES)-1:0] wr_addr,
   input  logic [LATENCY_BITS-1:0]        wr_data,
   output logic [LATENCY_BITS-1:0]        lat
);

   localparam int OP_AW = $clog2(NUM_OPCODES);

   logic [NUM_OPCODES-1:0]  valid_ff;
   logic                    fwd_valid_ff;
   logic [OP_AW-1:0]        fwd_addr_ff;
   logic [LATENCY_BITS-1:0] fwd_data_ff;
   logic [LATENCY_BITS-1:0] rd_data;
   logic [LATENCY_BITS-1:0] cur_data;

   ddt_ram #(
      .WIDTH (LATENCY_BITS),
      .DEPTH (NUM_OPCODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries never loaded read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // a write on the same edge as a read launch is missed by the ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ctl.rd) begin
         fwd_valid_ff <= ctl.wr;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // lookup for the request in stage one
   assign cur_data = (fwd_valid_ff && fwd_addr_ff == lk_addr) ? fwd_data_ff : rd_data;
   assign lat      = (lk_ok && valid_ff[lk_addr]) ? cur_data : '0;

endmodule

### rtl/ddt_regtab.sv
// register tracking table: last writer, finish time and false count per register
// three ram copies serve the two source reads and the destination read; depends on ddt_pkg, ddt_ram
module ddt_regtab import ddt_pkg::*; #(
   parameter int NUM_REGS  = DEF_NUM_REGS,
   parameter int MAX_INSTS = DEF_MAX_INSTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tab_ctl_type                       ctl,
   input  logic [$clog2(NUM_REGS)-1:0]       rd_addr_a,
   input  logic [$clog2(NUM_REGS)-1:0]       rd_addr_b,
   input  logic [$clog2(NUM_REGS)-1:0]       rd_addr_d,
   input  logic [$clog2(NUM_REGS)-1:0]       lk_addr_a,
   input  logic [$clog2(NUM_REGS)-1:0]       lk_addr_b,
   input  logic [$clog2(NUM_REGS)-1:0]       lk_addr_d,
   input  logic                              lk_ok_a,
   input  logic                              lk_ok_b,
   input  logic                              lk_ok_d,
   input  logic [$clog2(NUM_REGS)-1:0]       wr_addr,
   input  logic [$clog2(MAX_INSTS)-1:0]      wr_writer,
   input  logic [TIME_W-1:0]                 wr_fin,
   input  logic [FCNT_W-1:0]                 wr_cnt,
   output logic                              a_hit,
   output logic [$clog2(MAX_INSTS)-1:0]      a_writer,
   output logic [TIME_W-1:0]                 a_fin,
   output logic                              b_hit,
   output logic [$clog2(MAX_INSTS)-1:0]      b_writer,
   output logic [TIME_W-1:0]                 b_fin,
   output logic                              d_hit,
   output logic [FCNT_W-1:0]                 d_cnt
);

   localparam int REG_AW = $clog2(NUM_REGS);
   localparam int WR_W   = $clog2(MAX_INSTS);
   localparam int ENT_W  = WR_W + TIME_W + FCNT_W;
   localparam int NPORT  = 3;

   logic [NUM_REGS-1:0] valid_ff;
   logic                fwd_valid_ff;
   logic [REG_AW-1:0]   fwd_addr_ff;
   logic [ENT_W-1:0]    fwd_data_ff;
   logic [ENT_W-1:0]    wr_ent;
   logic [REG_AW-1:0]   rd_addr [NPORT];
   logic [REG_AW-1:0]   lk_addr [NPORT];
   logic [NPORT-1:0]    lk_ok;
   logic [ENT_W-1:0]    rd_data [NPORT];
   logic [ENT_W-1:0]    cur     [NPORT];
   logic [NPORT-1:0]    hit;

   assign wr_ent     = {wr_writer, wr_fin, wr_cnt};
   assign rd_addr[0] = rd_addr_a;
   assign rd_addr[1] = rd_addr_b;
   assign rd_addr[2] = rd_addr_d;
   assign lk_addr[0] = lk_addr_a;
   assign lk_addr[1] = lk_addr_b;
   assign lk_addr[2] = lk_addr_d;
   assign lk_ok      = {lk_ok_d, lk_ok_b, lk_ok_a};

   // one ram copy per read port, all written alike
   for (genvar p = 0; p < NPORT; p++) begin : g_copy
      ddt_ram #(
         .WIDTH (ENT_W),
         .DEPTH (NUM_REGS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ctl.wr),
         .wr_addr (wr_addr),
         .wr_data (wr_ent),
         .rd_en   (ctl.rd),
         .rd_addr (rd_addr[p]),
         .rd_data (rd_data[p])
      );

      // forward a write that landed on the read launch edge
      assign cur[p] = (fwd_valid_ff && fwd_addr_ff == lk_addr[p]) ? fwd_data_ff : rd_data[p];
      assign hit[p] = lk_ok[p] && valid_ff[lk_addr[p]];
   end

   // written-since-clear bits, cleared at once by reset or a clear request
   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         valid_ff <= '0;
      end else if (ctl.wr) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // forwarding record, refreshed at every read launch
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ctl.rd) begin
         fwd_valid_ff <= ctl.wr;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_ent;
      end
   end

   // unpack lookups
   assign a_hit    = hit[0];
   assign a_writer = cur[0][ENT_W-1 -: WR_W];
   assign a_fin    = cur[0][FCNT_W +: TIME_W];
   assign b_hit    = hit[1];
   assign b_writer = cur[1][ENT_W-1 -: WR_W];
   assign b_fin    = cur[1][FCNT_W +: TIME_W];
   assign d_hit    = hit[2];
   assign d_cnt    = cur[2][FCNT_W-1:0];

endmodule

### tb/dependency_trace_pkg.sv
`timescale 1ns / 1ps
// timing model of the dataflow dependency tracker and the checker of its responses
// depends on: ddt_pkg
package dependency_trace_pkg;
   import ddt_pkg::*;

   // one response as the block returns it
   typedef struct packed {
      logic                     status;
      logic [IDX_W-1:0]         inst_index;
      logic signed [PROD_W-1:0] producer_a;
      logic signed [PROD_W-1:0] producer_b;
      logic [TIME_W-1:0]        start_depth;
      logic [TIME_W-1:0]        finish_time;
      logic [TIME_W-1:0]        program_depth;
      logic [FCNT_W-1:0]        false_deps;
   } timing_t;

   class dependency_trace_model;
      bit [OPLAT_W-1:0] op_latency_tab [DEF_NUM_OPCODES];
      bit               has_writer [DEF_NUM_REGS];
      bit [PROD_W-1:0]  writer_of [DEF_NUM_REGS];
      bit [TIME_W-1:0]  done_at [DEF_NUM_REGS];
      bit [FCNT_W-1:0]  hazard_count [DEF_NUM_REGS];
      bit [FIELD_W-1:0] last_src_a;
      bit [FIELD_W-1:0] last_src_b;
      bit [FIELD_W-1:0] last_dest;
      bit               last_known;
      int unsigned      insts_seen;
      bit [TIME_W-1:0]  depth_peak;
      timing_t          pending_timings [$];
      int unsigned      errors;

      function new();
         foreach (op_latency_tab[i])
            op_latency_tab[i] = '0;
         errors = 0;
         start_new_trace();
      endfunction

      // forget all register tracking; the latency table stays
      function void start_new_trace();
         foreach (has_writer[i]) begin
            has_writer[i]   = 1'b0;
            writer_of[i]    = '0;
            done_at[i]      = '0;
            hazard_count[i] = '0;
         end
         last_src_a = '0;
         last_src_b = '0;
         last_dest  = '0;
         last_known = 1'b0;
         insts_seen = 0;
         depth_peak = '0;
      endfunction

      function int unsigned pending();
         return pending_timings.size();
      endfunction

      // timing of one trace instruction, updating the tracking state
      function timing_t predict_timing(bit [FIELD_W-1:0] opc, bit [FIELD_W-1:0] sa,
                                       bit [FIELD_W-1:0] sb, bit [FIELD_W-1:0] dst);
         timing_t         t;
         bit [TIME_W-1:0] fin_a;
         bit [TIME_W-1:0] fin_b;
         bit [TIME_W-1:0] start;
         bit [TIME_W:0]   sum;
         t = '0;
         // trace full: flagged, state untouched
         if (insts_seen >= DEF_MAX_INSTS) begin
            t.status        = 1'b1;
            t.producer_a    = NO_PROD;
            t.producer_b    = NO_PROD;
            t.program_depth = depth_peak;
            return t;
         end
         // producers of both sources
         fin_a = '0;
         fin_b = '0;
         t.producer_a = NO_PROD;
         t.producer_b = NO_PROD;
         if (sa < DEF_NUM_REGS && has_writer[sa]) begin
            t.producer_a = writer_of[sa];
            fin_a = done_at[sa];
         end
         if (sb < DEF_NUM_REGS && has_writer[sb]) begin
            t.producer_b = writer_of[sb];
            fin_b = done_at[sb];
         end
         start = (fin_a > fin_b) ? fin_a : fin_b;
         // finish time saturates
         sum = start;
         if (opc < DEF_NUM_OPCODES)
            sum = sum + op_latency_tab[opc];
         if (sum > TIME_MAX)
            sum = TIME_MAX;
         if (sum[TIME_W-1:0] > depth_peak)
            depth_peak = sum[TIME_W-1:0];
         // destination bookkeeping and false dependency count
         if (dst < DEF_NUM_REGS) begin
            has_writer[dst] = 1'b1;
            writer_of[dst]  = insts_seen[PROD_W-1:0];
            done_at[dst]    = sum[TIME_W-1:0];
            if (last_known && (dst == last_dest || dst == last_src_a || dst == last_src_b)
                && hazard_count[dst] < FCNT_MAX)
               hazard_count[dst]++;
            t.false_deps = hazard_count[dst];
         end
         t.inst_index    = insts_seen[IDX_W-1:0];
         t.start_depth   = start;
         t.finish_time   = sum[TIME_W-1:0];
         t.program_depth = depth_peak;
         last_src_a = sa;
         last_src_b = sb;
         last_dest  = dst;
         last_known = 1'b1;
         insts_seen++;
         return t;
      endfunction

      // an accepted request: update the model, queue any expected response
      function void note_request(bit [1:0] kind, bit [FIELD_W-1:0] opc, bit [FIELD_W-1:0] sa,
                                 bit [FIELD_W-1:0] sb, bit [FIELD_W-1:0] dst,
                                 bit [OPLAT_W-1:0] lat);
         case (kind)
            REQ_TRACE: pending_timings.push_back(predict_timing(opc, sa, sb, dst));
            REQ_LOAD: begin
               if (opc < DEF_NUM_OPCODES)
                  op_latency_tab[opc] = lat;
            end
            REQ_CLEAR: start_new_trace();
            default: ;
         endcase
      endfunction

      function void field_check(string name, int unsigned idx, logic signed [31:0] want,
                                logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: inst %0d %s mismatch: expected %0d, got %0d",
                        $time, idx, name, want, got);
         end
      endfunction

      // an accepted response against the oldest expectation
      function void check_response(timing_t got);
         timing_t want;
         if (pending_timings.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with nothing expected (inst %0d)",
                        $time, got.inst_index);
            return;
         end
         want = pending_timings.pop_front();
         field_check("status", want.inst_index, want.status, got.status);
         field_check("inst_index", want.inst_index, want.inst_index, got.inst_index);
         field_check("producer_a", want.inst_index, $signed(want.producer_a),
                     $signed(got.producer_a));
         field_check("producer_b", want.inst_index, $signed(want.producer_b),
                     $signed(got.producer_b));
         field_check("start_depth", want.inst_index, want.start_depth, got.start_depth);
         field_check("finish_time", want.inst_index, want.finish_time, got.finish_time);
         field_check("program_depth", want.inst_index, want.program_depth, got.program_depth);
         field_check("dest_false_deps", want.inst_index, want.false_deps, got.false_deps);
      endfunction
   endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 1ps
// top of the dataflow dependency tracker testbench: clock, reset, request and stall drivers
// depends on: ddt_pkg, dependency_trace_pkg, dataflow_dependency_tracker
module testbench;
   import ddt_pkg::*;
   import dependency_trace_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int unsigned REG_TOP = DEF_NUM_REGS - 1;
   localparam int unsigned OPC_TOP = DEF_NUM_OPCODES - 1;
   localparam int unsigned LAT_TOP = (1 << OPLAT_W) - 1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_type = REQ_TRACE;
   logic [FIELD_W-1:0]       req_opcode = '0;
   logic [FIELD_W-1:0]       req_src_a = '0;
   logic [FIELD_W-1:0]       req_src_b = '0;
   logic [FIELD_W-1:0]       req_dest_reg = '0;
   logic [OPLAT_W-1:0]       req_op_latency = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_status;
   logic [IDX_W-1:0]         rsp_inst_index;
   logic signed [PROD_W-1:0] rsp_producer_a;
   logic signed [PROD_W-1:0] rsp_producer_b;
   logic [TIME_W-1:0]        rsp_start_depth;
   logic [TIME_W-1:0]        rsp_finish_time;
   logic [TIME_W-1:0]        rsp_program_depth;
   logic [FCNT_W-1:0]        rsp_dest_false_deps;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned recent_dest = 0;

   dependency_trace_model trace_model = new();

   dataflow_dependency_tracker DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_opcode          (req_opcode),
      .req_src_a           (req_src_a),
      .req_src_b           (req_src_b),
      .req_dest_reg        (req_dest_reg),
      .req_op_latency      (req_op_latency),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_inst_index      (rsp_inst_index),
      .rsp_producer_a      (rsp_producer_a),
      .rsp_producer_b      (rsp_producer_b),
      .rsp_start_depth     (rsp_start_depth),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_program_depth   (rsp_program_depth),
      .rsp_dest_false_deps (rsp_dest_false_deps)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // note each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         trace_model.note_request(req_type, req_opcode, req_src_a, req_src_b, req_dest_reg,
                                  req_op_latency);
   end

   // check each accepted response
   always @(posedge clock) begin : rsp_monitor
      timing_t seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_status, rsp_inst_index, rsp_producer_a, rsp_producer_b,
                  rsp_start_depth, rsp_finish_time, rsp_program_depth, rsp_dest_false_deps};
         trace_model.check_response(seen);
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one request, after a random gap, held until accepted
   task automatic issue_request(input logic [1:0] kind, input logic [FIELD_W-1:0] opc, sa, sb,
                                dst, input logic [OPLAT_W-1:0] lat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_opcode     <= opc;
      req_src_a      <= sa;
      req_src_b      <= sb;
      req_dest_reg   <= dst;
      req_op_latency <= lat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic trace_inst(input int unsigned opc, sa, sb, dst);
      int unsigned lat;
      lat = $urandom_range(LAT_TOP);
      issue_request(REQ_TRACE, opc[FIELD_W-1:0], sa[FIELD_W-1:0], sb[FIELD_W-1:0],
                    dst[FIELD_W-1:0], lat[OPLAT_W-1:0]);
      recent_dest = dst;
   endtask

   task automatic load_lat(input int unsigned opc, lat);
      int unsigned sa, sb, dst;
      sa  = $urandom_range(REG_TOP);
      sb  = $urandom_range(REG_TOP);
      dst = $urandom_range(REG_TOP);
      issue_request(REQ_LOAD, opc[FIELD_W-1:0], sa[FIELD_W-1:0], sb[FIELD_W-1:0],
                    dst[FIELD_W-1:0], lat[OPLAT_W-1:0]);
   endtask

   // clear or unknown kind, other fields random
   task automatic issue_other(input logic [1:0] kind);
      int unsigned opc, sa, sb, dst, lat;
      opc = $urandom_range(OPC_TOP);
      sa  = $urandom_range(REG_TOP);
      sb  = $urandom_range(REG_TOP);
      dst = $urandom_range(REG_TOP);
      lat = $urandom_range(LAT_TOP);
      issue_request(kind, opc[FIELD_W-1:0], sa[FIELD_W-1:0], sb[FIELD_W-1:0],
                    dst[FIELD_W-1:0], lat[OPLAT_W-1:0]);
   endtask

   // sender holds off until every response is in
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (trace_model.pending() != 0);
   endtask

   // registers biased towards recent writes and a small set, so dependencies are common
   function automatic int unsigned pick_reg();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30)
         return recent_dest;
      else if (roll < 65)
         return $urandom_range(3);
      return $urandom_range(REG_TOP);
   endfunction

   function automatic int unsigned pick_latency();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return 0;
      else if (roll < 20)
         return LAT_TOP;
      else if (roll < 50)
         return $urandom_range(7);
      return $urandom_range(LAT_TOP);
   endfunction

   // random mix of instructions, table loads, clears and unknown kinds
   task automatic random_phase(input int unsigned count, idle_pct, stall_pct);
      int unsigned issued;
      int unsigned roll;
      issued = 0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (issued < count) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            issue_other(REQ_UNUSED);
         end else begin
            issued++;
            if (roll < 82)
               trace_inst($urandom_range(OPC_TOP), pick_reg(), pick_reg(), pick_reg());
            else if (roll < 95)
               load_lat($urandom_range(OPC_TOP), pick_latency());
            else
               issue_other(REQ_CLEAR);
         end
      end
      wait_for_responses();
   endtask

   // main sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table reads zero latency, no producers
      trace_inst(0, 0, 0, 0);
      // table extremes
      load_lat(0, LAT_TOP);
      load_lat(OPC_TOP, 0);
      load_lat(5, 1);
      // producer on the second source only
      trace_inst(0, REG_TOP, 0, REG_TOP);
      // destination read by the previous instruction
      trace_inst(OPC_TOP, REG_TOP, REG_TOP, 0);
      // unknown kind is ignored
      issue_other(REQ_UNUSED);
      // destination written by the previous instruction
      trace_inst(5, 3, 4, 0);
      // untouched destination, no count
      trace_inst(0, 0, 0, 7);
      // first instruction of a fresh trace counts nothing, table kept
      issue_other(REQ_CLEAR);
      trace_inst(0, 0, 0, 0);
      trace_inst(0, 0, 0, 0);
      load_lat(OPC_TOP, LAT_TOP);
      trace_inst(OPC_TOP, REG_TOP, REG_TOP, REG_TOP);
      trace_inst(OPC_TOP, REG_TOP, 0, REG_TOP);
      trace_inst(5, 1, 2, 3);
      issue_other(REQ_CLEAR);
      wait_for_responses();

      random_phase(375, 0, 0);
      random_phase(375, 47, 0);
      random_phase(375, 0, 47);
      random_phase(375, 38, 38);

      repeat (8) @(posedge clock);
      if (trace_model.errors == 0 && trace_model.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
